// ----- design/bf3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int SIDE_MIN    = 2;
  localparam int SIDE_RESET  = 8;
  localparam int SIDE_W      = 6;
  localparam int POS_W       = $clog2(MAX_SIDE);
  localparam int PIX_W       = 8;
  localparam int NUM_SLOTS   = 3;
  localparam int SLOT_W      = 2;
  localparam int STORE_DEPTH = NUM_SLOTS * MAX_SIDE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Neighborhood sum: up to nine pixels.
  localparam int SUM_MAX = 9 * ((1 << PIX_W) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  // Reciprocal multiply, floor(sum * m >> 15) == sum / d for every sum <= SUM_MAX.
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 14;
  localparam int RECIP_DIV4  = (1 << RECIP_SHIFT) / 4;
  localparam int RECIP_DIV6  = (1 << RECIP_SHIFT) / 6 + 1;
  localparam int RECIP_DIV9  = (1 << RECIP_SHIFT) / 9 + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_LAST,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_BY4,
    DIV_BY6,
    DIV_BY9
  } div_sel_e;

endpackage

`default_nettype wire

// ----- design/bf3_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/box_filter_3x3_edge_normalized_core.sv -----
// 3x3 box filter with edge normalization over a square 8-bit image of side
// image_side (2..32, written on the cfg channel; out-of-range values clamp, and
// any write restarts the image at row 0, column 0). Pixels enter one word at a
// time in raster order. Each output word is the truncated mean of the in-image
// part of a pixel's 3x3 neighborhood (divide by 4 at corners, 6 on edges, 9
// inside), tagged with its row and column. A pixel causes 0 to 4 output words,
// emitted as soon as their neighborhoods are complete; run_last_o marks the
// last word caused by one input word, and the pixels of the last row also emit
// the bottom row. Image rows live in one 96 x 8 single-read-port RAM, three
// row slots of 32 bytes. An input word that causes no output leaves the block
// idle; otherwise each output word passes through the states PICK, READ (n
// neighborhood reads through the single RAM read port, n = 4, 6 or 9), LAST,
// MUL and OUT, where it may wait for the output register to free up. Finished
// words sit in a one-word output register, so the input is stalled only while
// words of an earlier input are still being computed, or while a cfg write is
// offered; cfg is taken only when the block is idle and the output register is
// empty. Contents of the row RAM are undefined until written; every read
// within one complete image hits an entry written earlier in that image.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_edge_normalized_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration: image side
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [bf3_pkg::SIDE_W-1:0] cfg_data_i,
  // input pixel stream
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [bf3_pkg::PIX_W-1:0]  pixel_in_i,
  // smoothed pixel stream
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [bf3_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [bf3_pkg::POS_W-1:0]       out_row_o,
  output logic [bf3_pkg::POS_W-1:0]       out_column_o,
  output logic                            run_last_o
);

  import bf3_pkg::*;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [STORE_AW-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0]  col);
    store_addr = STORE_AW'(slot) * STORE_AW'(MAX_SIDE) + STORE_AW'(col);
  endfunction

  // Slot of a row k rows above the row held in 'slot' (k = 0..2), mod 3.
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                  input logic [1:0]        k);
    logic [SLOT_W:0] t;
    t = {1'b0, slot} + (SLOT_W + 1)'(NUM_SLOTS) - {1'b0, k};
    if (t >= (SLOT_W + 1)'(NUM_SLOTS)) begin
      t = t - (SLOT_W + 1)'(NUM_SLOTS);
    end
    slot_back = t[SLOT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;

  logic [SIDE_W-1:0]    side_q,   side_d;
  logic [POS_W-1:0]     in_row_q, in_row_d;
  logic [POS_W-1:0]     in_col_q, in_col_d;
  logic [SLOT_W-1:0]    in_slot_q, in_slot_d;

  // input word being worked on
  logic [POS_W-1:0]     cap_row_q, cap_col_q;
  logic [SLOT_W-1:0]    cap_slot_q;
  logic [3:0]           mask_q, mask_d;     // pending outputs, in emit order

  // output word being worked on
  logic [POS_W-1:0]     ctr_row_q, ctr_col_q;
  logic [POS_W-1:0]     rhi_q, clo_q, chi_q;
  logic [POS_W-1:0]     rd_row_q, rd_col_q;
  logic                 rd_vld_q;
  div_sel_e             div_sel_q;
  logic                 last_flag_q;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [PROD_W-1:0]    prod_q;

  // output register
  logic                 out_vld_q;
  logic [PIX_W-1:0]     out_pix_q;
  logic [POS_W-1:0]     out_row_q, out_col_q;
  logic                 out_last_q;
  logic                 out_load;

  logic [POS_W-1:0]     side_last;
  logic                 in_acc, out_acc, cfg_acc;
  logic                 ram_we, ram_re;
  logic [PIX_W-1:0]     ram_rdata;
  logic [STORE_AW-1:0]  ram_raddr;

  assign side_last = POS_W'(side_q - SIDE_W'(1));
  assign in_acc    = in_valid_i  && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign cfg_acc   = cfg_valid_i && cfg_ready_o;
  // finished word moves into the output register when it is free or draining
  assign out_load  = (state_q == ST_OUT) && (!out_vld_q || out_acc);

  // ---------------------------------------------------------------------------
  // Row store
  // ---------------------------------------------------------------------------
  assign ram_raddr = store_addr(slot_back(cap_slot_q, 2'(cap_row_q - rd_row_q)), rd_col_q);

  bf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_addr(in_slot_q, in_col_q)),
    .wdata_i (pixel_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Raster position and side register
  // ---------------------------------------------------------------------------
  always_comb begin
    side_d    = side_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    in_slot_d = in_slot_q;
    priority if (cfg_acc) begin
      if (cfg_data_i < SIDE_W'(SIDE_MIN)) begin
        side_d = SIDE_W'(SIDE_MIN);
      end else if (cfg_data_i > SIDE_W'(MAX_SIDE)) begin
        side_d = SIDE_W'(MAX_SIDE);
      end else begin
        side_d = cfg_data_i;
      end
      in_row_d  = '0;
      in_col_d  = '0;
      in_slot_d = '0;
    end else if (in_acc) begin
      if (in_col_q == side_last) begin
        in_col_d = '0;
        if (in_row_q == side_last) begin
          in_row_d  = '0;
          in_slot_d = '0;
        end else begin
          in_row_d  = in_row_q + POS_W'(1);
          in_slot_d = (in_slot_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : in_slot_q + SLOT_W'(1);
        end
      end else begin
        in_col_d = in_col_q + POS_W'(1);
      end
    end
  end

  // Outputs caused by the input at (r, c), in emit order:
  //   bit 0 (r-1, c-1), bit 1 (r-1, c), bit 2 (r, c-1), bit 3 (r, c).
  logic [3:0] new_mask;
  always_comb begin
    new_mask[0] = (in_row_q != '0) && (in_col_q != '0);
    new_mask[1] = (in_row_q != '0) && (in_col_q == side_last);
    new_mask[2] = (in_row_q == side_last) && (in_col_q != '0);
    new_mask[3] = (in_row_q == side_last) && (in_col_q == side_last);
  end

  // ---------------------------------------------------------------------------
  // Pick next output: center, clipped bounds, divisor
  // ---------------------------------------------------------------------------
  logic [3:0]       pick_bit;
  logic [POS_W-1:0] pick_row, pick_col;
  logic [POS_W-1:0] pick_rlo, pick_rhi, pick_clo, pick_chi;
  logic             pick_r3, pick_c3;
  div_sel_e         pick_div;

  always_comb begin
    pick_bit = mask_q & (~mask_q + 4'd1);
    pick_row = (pick_bit[0] || pick_bit[1]) ? cap_row_q - POS_W'(1) : cap_row_q;
    pick_col = (pick_bit[0] || pick_bit[2]) ? cap_col_q - POS_W'(1) : cap_col_q;
    pick_rlo = (pick_row != '0)        ? pick_row - POS_W'(1) : pick_row;
    pick_rhi = (pick_row != side_last) ? pick_row + POS_W'(1) : pick_row;
    pick_clo = (pick_col != '0)        ? pick_col - POS_W'(1) : pick_col;
    pick_chi = (pick_col != side_last) ? pick_col + POS_W'(1) : pick_col;
    pick_r3  = (pick_rhi - pick_rlo) == POS_W'(2);
    pick_c3  = (pick_chi - pick_clo) == POS_W'(2);
    if (pick_r3 && pick_c3) begin
      pick_div = DIV_BY9;
    end else if (pick_r3 || pick_c3) begin
      pick_div = DIV_BY6;
    end else begin
      pick_div = DIV_BY4;
    end
  end

  logic read_done;
  assign read_done = (rd_row_q == rhi_q) && (rd_col_q == chi_q);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (new_mask != '0)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: state_d = ST_READ;
      ST_READ: begin
        if (read_done) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = (mask_q != '0) ? ST_PICK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
    cfg_ready_o = (state_q == ST_IDLE) && !out_vld_q;
    out_valid_o = out_vld_q;
    ram_we      = in_acc;
    ram_re      = (state_q == ST_READ);
  end

  // pending mask: load on accept, drop the picked output at pick time
  always_comb begin
    mask_d = mask_q;
    if (in_acc) begin
      mask_d = new_mask;
    end else if (state_q == ST_PICK) begin
      mask_d = mask_q & ~pick_bit;
    end
  end

  // accumulate read data in the cycle after each read issue
  always_comb begin
    if (state_q == ST_PICK) begin
      sum_d = '0;
    end else if (rd_vld_q) begin
      sum_d = sum_q + SUM_W'(ram_rdata);
    end else begin
      sum_d = sum_q;
    end
  end

  logic [RECIP_W-1:0] recip;
  always_comb begin
    unique case (div_sel_q)
      DIV_BY4: recip = RECIP_W'(RECIP_DIV4);
      DIV_BY6: recip = RECIP_W'(RECIP_DIV6);
      DIV_BY9: recip = RECIP_W'(RECIP_DIV9);
      default: recip = RECIP_W'(RECIP_DIV4);
    endcase
  end

  assign pixel_out_o  = out_pix_q;
  assign out_row_o    = out_row_q;
  assign out_column_o = out_col_q;
  assign run_last_o   = out_last_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      side_q    <= SIDE_W'(SIDE_RESET);
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_slot_q <= '0;
      mask_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      side_q    <= side_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      in_slot_q <= in_slot_d;
      mask_q    <= mask_d;
      rd_vld_q  <= ram_re;
      out_vld_q <= out_load || (out_vld_q && !out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (in_acc) begin
      cap_row_q  <= in_row_q;
      cap_col_q  <= in_col_q;
      cap_slot_q <= in_slot_q;
    end
    if (state_q == ST_PICK) begin
      ctr_row_q   <= pick_row;
      ctr_col_q   <= pick_col;
      rhi_q       <= pick_rhi;
      clo_q       <= pick_clo;
      chi_q       <= pick_chi;
      rd_row_q    <= pick_rlo;
      rd_col_q    <= pick_clo;
      div_sel_q   <= pick_div;
      last_flag_q <= (mask_q & ~pick_bit) == '0;
    end else if (state_q == ST_READ) begin
      if (rd_col_q == chi_q) begin
        rd_col_q <= clo_q;
        rd_row_q <= rd_row_q + POS_W'(1);
      end else begin
        rd_col_q <= rd_col_q + POS_W'(1);
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(recip);
    end
    if (out_load) begin
      out_pix_q  <= prod_q[RECIP_SHIFT +: PIX_W];
      out_row_q  <= ctr_row_q;
      out_col_q  <= ctr_col_q;
      out_last_q <= last_flag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, in_col_q} < side_q) && ({1'b0, in_row_q} < side_q))
    else $error("raster position outside image");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (sum_q <= SUM_W'(SUM_MAX)))
    else $error("neighborhood sum out of range");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_flag_q) |=> (state_q == ST_IDLE))
    else $error("run did not end after last word");

  a_more_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !last_flag_q) |=> (state_q == ST_PICK))
    else $error("run ended before last word");

  a_out_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, out_row_o} < side_q) && ({1'b0, out_column_o} < side_q)))
    else $error("output position outside image");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_out_o) &&
      $stable(out_row_o) && $stable(out_column_o) && $stable(run_last_o)))
    else $error("stalled output word changed");

endmodule

`default_nettype wire
